### src/vcra_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcra_pkg
// Shared sizes, codes and helpers for the virtual-channel router allocator.
// ---------------------------------------------------------------------------
package vcra_pkg;

   localparam int NUM_PORTS = 5;
   localparam int NUM_VCS   = 4;
   localparam int BUF_DEPTH = 4;

   localparam int PW  = $clog2(NUM_PORTS);
   localparam int VCW = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
   localparam int HW  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CW  = $clog2(BUF_DEPTH + 1);
   localparam int NUM_SLOTS = NUM_PORTS * NUM_VCS * BUF_DEPTH;
   localparam int AW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // flit slot: route(3) type(2) tag(16)
   localparam int FLIT_W = 21;
   localparam int CRED_W = 5;

   localparam logic [CRED_W-1:0] DEPTH_RESET = 5'd4;
   localparam logic [2:0]        LOCAL_RESET = 3'd0;

   // event kinds
   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_FLIT   = 2'd1;
   localparam logic [1:0] KIND_CREDIT = 2'd2;

   // flit types
   localparam logic [1:0] TYPE_HEAD = 2'd0;
   localparam logic [1:0] TYPE_TAIL = 2'd2;

   // register indexes
   localparam logic CSR_DEPTH = 1'b0;
   localparam logic CSR_LOCAL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEND_RD,
      ST_SEND_OUT,
      ST_SW_ALLOC,
      ST_VC_RD,
      ST_VC_ALLOC
   } state_type;

   // ring increment of a VC pointer; s < 2*NUM_VCS
   function automatic logic [VCW-1:0] wrap_vc(input logic [VCW:0] s);
      logic [VCW:0] r;
      r = (s >= (VCW+1)'(NUM_VCS)) ? s - (VCW+1)'(NUM_VCS) : s;
      return r[VCW-1:0];
   endfunction

   // flit store address of one slot
   function automatic logic [AW-1:0] flit_addr(input logic [PW-1:0] p,
                                               input logic [VCW-1:0] v,
                                               input logic [HW-1:0] s);
      return (AW'(p) * AW'(NUM_VCS) + AW'(v)) * AW'(BUF_DEPTH) + AW'(s);
   endfunction

endpackage
`default_nettype wire

### src/vcra_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcra_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module vcra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### src/vc_router_allocator_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vc_router_allocator_core
// Input-buffered VC router core: per-VC flit FIFOs in one RAM, credit flow
// control, round-robin switch allocation and lowest-free VC allocation.
// ---------------------------------------------------------------------------
//   channel | direction | transfer
//   req_    | in        | one event: tick, flit arrival or credit arrival
//   rsp_    | out       | one sent flit with its returned credit
//   csr_    | in        | register write, no wait
//
// Flit and credit events do not raise req_stall. After its transfer a tick
// holds req_stall while it walks the ports to send granted flits, runs
// switch allocation and walks the ports again for VC allocation; the walks
// are set by the single read port of the flit store RAM, which is read once
// per sent flit and once per VC allocation request.
// Reset (synchronous) empties all FIFOs, drops routes and grants and loads
// every credit counter with the depth reset value; no clearing pass.
// A stalled result holds the send walk; events wait while a tick runs.
module vc_router_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [2:0]  req_port,
   input  wire logic [1:0]  req_vchan,
   input  wire logic [1:0]  req_flit_type,
   input  wire logic [15:0] req_flit_tag,
   input  wire logic [2:0]  req_route_port,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_out_port,
   output logic [1:0]       rsp_out_vchan,
   output logic [15:0]      rsp_sent_tag,
   output logic [1:0]       rsp_sent_type,
   output logic [2:0]       rsp_credit_port,
   output logic [1:0]       rsp_credit_vchan,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [4:0]  csr_wr_data
);

   localparam int NP  = vcra_pkg::NUM_PORTS;
   localparam int NV  = vcra_pkg::NUM_VCS;
   localparam int BD  = vcra_pkg::BUF_DEPTH;
   localparam int PW  = vcra_pkg::PW;
   localparam int VCW = vcra_pkg::VCW;
   localparam int HW  = vcra_pkg::HW;
   localparam int CW  = vcra_pkg::CW;
   localparam int AW  = vcra_pkg::AW;
   localparam int FW  = vcra_pkg::FLIT_W;
   localparam int RW  = vcra_pkg::CRED_W;

   vcra_pkg::state_type state_ff, state_in;

   logic [PW-1:0]  idx_ff, idx_in;
   logic [NP-1:0]  send_mask_ff, send_mask_in;
   logic [VCW-1:0] vc_sel_ff, vc_sel_in;

   logic [CW-1:0]  cnt_ff   [NP][NV], cnt_in   [NP][NV];
   logic [HW-1:0]  head_ff  [NP][NV], head_in  [NP][NV];
   logic           rt_vld_ff[NP][NV], rt_vld_in[NP][NV];
   logic [PW-1:0]  rt_port_ff[NP][NV], rt_port_in[NP][NV];
   logic [VCW-1:0] rt_vc_ff [NP][NV], rt_vc_in [NP][NV];
   logic [RW-1:0]  cred_ff  [NP][NV], cred_in  [NP][NV];

   logic           gnt_vld_ff [NP], gnt_vld_in [NP];
   logic [VCW-1:0] gnt_invc_ff[NP], gnt_invc_in[NP];
   logic [PW-1:0]  gnt_port_ff[NP], gnt_port_in[NP];
   logic [VCW-1:0] gnt_vc_ff  [NP], gnt_vc_in  [NP];

   logic [VCW-1:0] vptr_ff[NP], vptr_in[NP];
   logic [VCW-1:0] sin_ff [NP], sin_in [NP];
   logic [VCW-1:0] sout_ff[NP], sout_in[NP];

   logic [RW-1:0]  cfg_depth_ff, cfg_depth_in;
   logic [2:0]     cfg_local_ff, cfg_local_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     out_port_ff;
   logic [1:0]     out_vchan_ff;
   logic [15:0]    sent_tag_ff;
   logic [1:0]     sent_type_ff;
   logic [2:0]     credit_port_ff;
   logic [1:0]     credit_vchan_ff;
   logic           last_ff;
   logic           rsp_load;
   logic           last_next;

   logic           ram_we, ram_re;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [FW-1:0]  ram_wdata, ram_rdata;

   logic           req_xfer, out_free, idx_last, send_go;
   logic           vc_found;
   logic [VCW-1:0] vc_cand;

   // flit store
   vcra_ram #(.WIDTH(FW), .DEPTH(vcra_pkg::NUM_SLOTS)) u_flit_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != vcra_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_last  = (idx_ff == PW'(NP - 1));
   assign send_go   = send_mask_ff[idx_ff];

   // later senders in this tick
   always_comb begin
      last_next = 1'b1;
      for (int j = 0; j < NP; j++) begin
         if (j > int'(idx_ff) && send_mask_ff[j]) begin
            last_next = 1'b0;
         end
      end
   end

   // VC allocation candidate of the current port
   always_comb begin
      logic [VCW-1:0] v;
      vc_found = 1'b0;
      vc_cand  = '0;
      for (int i = 0; i < NV; i++) begin
         v = vcra_pkg::wrap_vc((VCW+1)'(vptr_ff[idx_ff]) + (VCW+1)'(i));
         if (!vc_found && !rt_vld_ff[idx_ff][v] && cnt_ff[idx_ff][v] != '0) begin
            vc_found = 1'b1;
            vc_cand  = v;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vcra_pkg::ST_IDLE: begin
            if (req_xfer && req_kind == vcra_pkg::KIND_TICK) begin
               state_in = vcra_pkg::ST_SEND_RD;
            end
         end
         vcra_pkg::ST_SEND_RD: begin
            if (send_go) begin
               state_in = vcra_pkg::ST_SEND_OUT;
            end else if (idx_last) begin
               state_in = vcra_pkg::ST_SW_ALLOC;
            end
         end
         vcra_pkg::ST_SEND_OUT: begin
            if (out_free) begin
               state_in = idx_last ? vcra_pkg::ST_SW_ALLOC : vcra_pkg::ST_SEND_RD;
            end
         end
         vcra_pkg::ST_SW_ALLOC: begin
            state_in = vcra_pkg::ST_VC_RD;
         end
         vcra_pkg::ST_VC_RD: begin
            if (vc_found) begin
               state_in = vcra_pkg::ST_VC_ALLOC;
            end else if (idx_last) begin
               state_in = vcra_pkg::ST_IDLE;
            end
         end
         vcra_pkg::ST_VC_ALLOC: begin
            state_in = idx_last ? vcra_pkg::ST_IDLE : vcra_pkg::ST_VC_RD;
         end
         default: begin
            state_in = vcra_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and state updates
   always_comb begin
      logic [CW:0]    slot_sum;
      logic [HW:0]    head_nx;
      logic [PW-1:0]  gp, rp_c;
      logic [VCW-1:0] gv, iv, v, vc;
      logic           req_ok [NP];
      logic [VCW-1:0] req_v  [NP];
      logic           sel_found, free_found;
      logic [PW-1:0]  sel;
      logic [VCW-1:0] sel_vc, free_vc;
      logic [NV-1:0]  used;
      logic [PW-1:0]  o;
      logic [PW-1:0]  ep;
      logic [VCW-1:0] ev;

      idx_in       = idx_ff;
      send_mask_in = send_mask_ff;
      vc_sel_in    = vc_sel_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      rt_vld_in    = rt_vld_ff;
      rt_port_in   = rt_port_ff;
      rt_vc_in     = rt_vc_ff;
      cred_in      = cred_ff;
      gnt_vld_in   = gnt_vld_ff;
      gnt_invc_in  = gnt_invc_ff;
      gnt_port_in  = gnt_port_ff;
      gnt_vc_in    = gnt_vc_ff;
      vptr_in      = vptr_ff;
      sin_in       = sin_ff;
      sout_in      = sout_ff;
      cfg_depth_in = cfg_depth_ff;
      cfg_local_in = cfg_local_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = '0;
      ram_raddr    = '0;
      ram_wdata    = '0;
      rsp_load     = 1'b0;
      ep           = PW'(req_port);
      ev           = VCW'(req_vchan);

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            vcra_pkg::CSR_DEPTH: cfg_depth_in = csr_wr_data;
            vcra_pkg::CSR_LOCAL: cfg_local_in = csr_wr_data[2:0];
            default: ;
         endcase
      end

      case (state_ff)
         vcra_pkg::ST_IDLE: begin
            if (req_xfer) begin
               case (req_kind)
                  vcra_pkg::KIND_TICK: begin
                     for (int p = 0; p < NP; p++) begin
                        send_mask_in[p] = gnt_vld_ff[p]
                           && cred_ff[gnt_port_ff[p]][gnt_vc_ff[p]] != '0
                           && cnt_ff[p][gnt_invc_ff[p]] != '0;
                     end
                     idx_in = '0;
                  end
                  vcra_pkg::KIND_FLIT: begin
                     if (int'(req_port) < NP && int'(req_vchan) < NV
                         && cnt_ff[ep][ev] < CW'(BD)) begin
                        slot_sum = (CW+1)'(head_ff[ep][ev]) + (CW+1)'(cnt_ff[ep][ev]);
                        if (slot_sum >= (CW+1)'(BD)) begin
                           slot_sum = slot_sum - (CW+1)'(BD);
                        end
                        rp_c = (int'(req_route_port) >= NP) ? PW'(NP - 1)
                                                             : PW'(req_route_port);
                        ram_we    = 1'b1;
                        ram_waddr = vcra_pkg::flit_addr(ep, ev, HW'(slot_sum));
                        ram_wdata = {3'(rp_c), req_flit_type, req_flit_tag};
                        cnt_in[ep][ev] = cnt_ff[ep][ev] + CW'(1);
                     end
                  end
                  vcra_pkg::KIND_CREDIT: begin
                     if (int'(req_port) < NP && int'(req_vchan) < NV
                         && cred_ff[ep][ev] < cfg_depth_ff) begin
                        cred_in[ep][ev] = cred_ff[ep][ev] + RW'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end

         // read the front flit of a granted VC
         vcra_pkg::ST_SEND_RD: begin
            iv = gnt_invc_ff[idx_ff];
            if (send_go) begin
               ram_re    = 1'b1;
               ram_raddr = vcra_pkg::flit_addr(idx_ff, iv, head_ff[idx_ff][iv]);
            end else begin
               idx_in = idx_last ? '0 : idx_ff + PW'(1);
            end
         end

         // hand the flit to the output register and pop it
         vcra_pkg::ST_SEND_OUT: begin
            iv = gnt_invc_ff[idx_ff];
            gp = gnt_port_ff[idx_ff];
            gv = gnt_vc_ff[idx_ff];
            if (out_free) begin
               rsp_load = 1'b1;
               head_nx  = (HW+1)'(head_ff[idx_ff][iv]) + (HW+1)'(1);
               head_in[idx_ff][iv] = (head_nx == (HW+1)'(BD)) ? '0 : HW'(head_nx);
               cnt_in[idx_ff][iv]  = cnt_ff[idx_ff][iv] - CW'(1);
               if (3'(gp) != cfg_local_ff) begin
                  cred_in[gp][gv] = cred_ff[gp][gv] - RW'(1);
               end
               if (ram_rdata[17:16] == vcra_pkg::TYPE_TAIL) begin
                  rt_vld_in[idx_ff][iv] = 1'b0;
               end
               idx_in = idx_last ? '0 : idx_ff + PW'(1);
            end
         end

         // round-robin switch allocation
         vcra_pkg::ST_SW_ALLOC: begin
            for (int p = 0; p < NP; p++) begin
               req_ok[p] = 1'b0;
               req_v[p]  = '0;
               for (int i = 0; i < NV; i++) begin
                  v = vcra_pkg::wrap_vc((VCW+1)'(sin_ff[p]) + (VCW+1)'(i));
                  if (!req_ok[p] && rt_vld_ff[p][v] && cnt_ff[p][v] != '0) begin
                     req_ok[p] = 1'b1;
                     req_v[p]  = v;
                  end
               end
            end
            for (int p = 0; p < NP; p++) begin
               gnt_vld_in[p] = 1'b0;
            end
            for (int oi = 0; oi < NP; oi++) begin
               sel_found = 1'b0;
               sel       = '0;
               sel_vc    = '0;
               for (int i = 0; i < NV; i++) begin
                  vc = vcra_pkg::wrap_vc((VCW+1)'(sout_ff[oi]) + (VCW+1)'(i));
                  for (int p = 0; p < NP; p++) begin
                     if (!sel_found && req_ok[p]
                         && rt_port_ff[p][req_v[p]] == PW'(oi)
                         && rt_vc_ff[p][req_v[p]] == vc) begin
                        sel_found = 1'b1;
                        sel       = PW'(p);
                        sel_vc    = vc;
                     end
                  end
               end
               if (sel_found) begin
                  gnt_vld_in[sel]  = 1'b1;
                  gnt_invc_in[sel] = req_v[sel];
                  gnt_port_in[sel] = PW'(oi);
                  gnt_vc_in[sel]   = sel_vc;
                  sin_in[sel]  = vcra_pkg::wrap_vc((VCW+1)'(sin_ff[sel]) + (VCW+1)'(1));
                  sout_in[oi]  = vcra_pkg::wrap_vc((VCW+1)'(sel_vc) + (VCW+1)'(1));
               end
            end
            idx_in = '0;
         end

         // look up the front flit of the candidate VC
         vcra_pkg::ST_VC_RD: begin
            if (vc_found) begin
               ram_re    = 1'b1;
               ram_raddr = vcra_pkg::flit_addr(idx_ff, vc_cand, head_ff[idx_ff][vc_cand]);
               vc_sel_in = vc_cand;
            end else begin
               idx_in = idx_last ? '0 : idx_ff + PW'(1);
            end
         end

         // head flit takes the lowest free VC of its route port
         vcra_pkg::ST_VC_ALLOC: begin
            o    = PW'(ram_rdata[20:18]);
            used = '0;
            for (int q = 0; q < NP; q++) begin
               for (int w = 0; w < NV; w++) begin
                  if (rt_vld_ff[q][w] && rt_port_ff[q][w] == o) begin
                     used[rt_vc_ff[q][w]] = 1'b1;
                  end
               end
            end
            free_found = 1'b0;
            free_vc    = '0;
            for (int w = 0; w < NV; w++) begin
               if (!free_found && !used[w]) begin
                  free_found = 1'b1;
                  free_vc    = VCW'(w);
               end
            end
            if (ram_rdata[17:16] == vcra_pkg::TYPE_HEAD && free_found) begin
               rt_vld_in[idx_ff][vc_sel_ff]  = 1'b1;
               rt_port_in[idx_ff][vc_sel_ff] = o;
               rt_vc_in[idx_ff][vc_sel_ff]   = free_vc;
               vptr_in[idx_ff] = vcra_pkg::wrap_vc((VCW+1)'(vptr_ff[idx_ff]) + (VCW+1)'(1));
            end
            idx_in = idx_last ? '0 : idx_ff + PW'(1);
         end

         default: ;
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vcra_pkg::ST_IDLE;
         idx_ff       <= '0;
         send_mask_ff <= '0;
         vc_sel_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_depth_ff <= vcra_pkg::DEPTH_RESET;
         cfg_local_ff <= vcra_pkg::LOCAL_RESET;
         for (int p = 0; p < NP; p++) begin
            gnt_vld_ff[p] <= 1'b0;
            vptr_ff[p]    <= '0;
            sin_ff[p]     <= '0;
            sout_ff[p]    <= '0;
            for (int w = 0; w < NV; w++) begin
               cnt_ff[p][w]    <= '0;
               head_ff[p][w]   <= '0;
               rt_vld_ff[p][w] <= 1'b0;
               cred_ff[p][w]   <= vcra_pkg::DEPTH_RESET;
            end
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         send_mask_ff <= send_mask_in;
         vc_sel_ff    <= vc_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_depth_ff <= cfg_depth_in;
         cfg_local_ff <= cfg_local_in;
         gnt_vld_ff   <= gnt_vld_in;
         vptr_ff      <= vptr_in;
         sin_ff       <= sin_in;
         sout_ff      <= sout_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         rt_vld_ff    <= rt_vld_in;
         cred_ff      <= cred_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rt_port_ff  <= rt_port_in;
      rt_vc_ff    <= rt_vc_in;
      gnt_invc_ff <= gnt_invc_in;
      gnt_port_ff <= gnt_port_in;
      gnt_vc_ff   <= gnt_vc_in;
      if (rsp_load) begin
         out_port_ff     <= 3'(gnt_port_ff[idx_ff]);
         out_vchan_ff    <= 2'(gnt_vc_ff[idx_ff]);
         sent_tag_ff     <= ram_rdata[15:0];
         sent_type_ff    <= ram_rdata[17:16];
         credit_port_ff  <= 3'(idx_ff);
         credit_vchan_ff <= 2'(gnt_invc_ff[idx_ff]);
         last_ff         <= last_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_port     = out_port_ff;
   assign rsp_out_vchan    = out_vchan_ff;
   assign rsp_sent_tag     = sent_tag_ff;
   assign rsp_sent_type    = sent_type_ff;
   assign rsp_credit_port  = credit_port_ff;
   assign rsp_credit_vchan = credit_vchan_ff;
   assign rsp_last         = last_ff;

endmodule
`default_nettype wire

### src/vcra_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcra_checker
// Port-level checks of the router allocator core, bound to the top level.
// ---------------------------------------------------------------------------
module vcra_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_out_port,
   input wire logic [2:0] rsp_credit_port,
   input wire logic [1:0] rsp_credit_vchan
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // reset leaves no result pending and the input open
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state after reset not idle");

   // a sent flit names real ports
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_out_port) < vcra_pkg::NUM_PORTS
                 && int'(rsp_credit_port) < vcra_pkg::NUM_PORTS)
      else $error("result port out of range");

   // a returned credit names a real VC
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_credit_vchan) < vcra_pkg::NUM_VCS)
      else $error("credit VC out of range");

   // results only come out of a running tick
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result outside a tick");

endmodule

bind vc_router_allocator_core vcra_checker u_vcra_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_port     (rsp_out_port),
   .rsp_credit_port  (rsp_credit_port),
   .rsp_credit_vchan (rsp_credit_vchan)
);
`default_nettype wire

### test/vc_router_allocator_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vc_router_allocator_core_tb
// Self-checking bench for the VC router core. Events (ticks, flit arrivals,
// credit arrivals) are driven with random bursts and gaps. A cycle-free
// predictor of FIFOs, routes, credits and allocators computes the flits each
// tick sends, and every rsp_ transfer is checked against the oldest one.
// ---------------------------------------------------------------------------
module vc_router_allocator_core_tb;

   localparam int         NPORT     = vcra_pkg::NUM_PORTS;
   localparam int         NVC       = vcra_pkg::NUM_VCS;
   localparam int         BDEPTH    = vcra_pkg::BUF_DEPTH;
   localparam logic [1:0] KIND_BAD  = 2'd3;
   localparam logic [1:0] TYPE_BODY = 2'd1;
   localparam logic [1:0] TYPE_ODD  = 2'd3;
   localparam int         IDLE_GAP  = 60;

   typedef struct packed {
      logic [2:0]  out_port;
      logic [1:0]  out_vchan;
      logic [15:0] tag;
      logic [1:0]  ftype;
      logic [2:0]  credit_port;
      logic [1:0]  credit_vchan;
      logic        last;
   } sent_flit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = vcra_pkg::KIND_TICK;
   logic [2:0]  req_port = '0;
   logic [1:0]  req_vchan = '0;
   logic [1:0]  req_flit_type = vcra_pkg::TYPE_HEAD;
   logic [15:0] req_flit_tag = '0;
   logic [2:0]  req_route_port = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_out_port;
   logic [1:0]  rsp_out_vchan;
   logic [15:0] rsp_sent_tag;
   logic [1:0]  rsp_sent_type;
   logic [2:0]  rsp_credit_port;
   logic [1:0]  rsp_credit_vchan;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = vcra_pkg::CSR_DEPTH;
   logic [4:0]  csr_wr_data = '0;

   vc_router_allocator_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [15:0] buf_tag   [NPORT][NVC][BDEPTH];
   logic [1:0]  buf_type  [NPORT][NVC][BDEPTH];
   int          buf_route [NPORT][NVC][BDEPTH];
   int          buf_cnt   [NPORT][NVC];
   int          buf_head  [NPORT][NVC];
   bit          vc_bound  [NPORT][NVC];
   int          bound_port[NPORT][NVC];
   int          bound_vc  [NPORT][NVC];
   int          credits   [NPORT][NVC];
   bit          gnt_v     [NPORT];
   int          gnt_in    [NPORT];
   int          gnt_port  [NPORT];
   int          gnt_vc    [NPORT];
   int          va_ptr    [NPORT];
   int          sin_ptr   [NPORT];
   int          sout_ptr  [NPORT];
   int          depth_reg = 4;
   int          local_reg = 0;

   sent_flit_type sent_q[$];
   int          errors = 0;
   int          events_sent = 0;
   int          flits_checked = 0;
   int          burst_left = 0;
   int          stall_pct = 0;
   int          stall_run = 0;

   // tick: send granted flits, then switch allocation, then VC allocation
   function automatic void predict_tick();
      int req_v[NPORT];
      int req_o[NPORT];
      bit used[NVC];
      int p, o, i, v, q, iv, sel, selvc, n;
      sent_flit_type f;
      n = 0;
      for (p = 0; p < NPORT; p++) begin
         if (!gnt_v[p]) continue;
         iv = gnt_in[p];
         if (credits[gnt_port[p]][gnt_vc[p]] == 0 || buf_cnt[p][iv] == 0) continue;
         f.out_port     = 3'(gnt_port[p]);
         f.out_vchan    = 2'(gnt_vc[p]);
         f.tag          = buf_tag[p][iv][buf_head[p][iv]];
         f.ftype        = buf_type[p][iv][buf_head[p][iv]];
         f.credit_port  = 3'(p);
         f.credit_vchan = 2'(iv);
         f.last         = 1'b0;
         buf_head[p][iv] = (buf_head[p][iv] + 1) % BDEPTH;
         buf_cnt[p][iv]--;
         if (gnt_port[p] != local_reg) credits[gnt_port[p]][gnt_vc[p]]--;
         if (f.ftype == vcra_pkg::TYPE_TAIL) vc_bound[p][iv] = 0;
         sent_q = {sent_q, f};
         n++;
      end
      for (p = 0; p < NPORT; p++) gnt_v[p] = 0;
      if (n > 0) sent_q[sent_q.size()-1].last = 1'b1;

      // switch allocation
      for (p = 0; p < NPORT; p++) begin
         req_v[p] = -1;
         for (i = 0; i < NVC; i++) begin
            v = (sin_ptr[p] + i) % NVC;
            if (vc_bound[p][v] && buf_cnt[p][v] > 0) begin
               req_v[p] = v;
               break;
            end
         end
      end
      for (o = 0; o < NPORT; o++) begin
         sel = -1;
         selvc = 0;
         for (i = 0; i < NVC && sel < 0; i++) begin
            v = (sout_ptr[o] + i) % NVC;
            for (p = 0; p < NPORT; p++) begin
               if (req_v[p] < 0) continue;
               if (bound_port[p][req_v[p]] == o && bound_vc[p][req_v[p]] == v) begin
                  sel = p;
                  selvc = v;
                  break;
               end
            end
         end
         if (sel >= 0) begin
            gnt_v[sel]    = 1;
            gnt_in[sel]   = req_v[sel];
            gnt_port[sel] = o;
            gnt_vc[sel]   = selvc;
            sin_ptr[sel]  = (sin_ptr[sel] + 1) % NVC;
            sout_ptr[o]   = (selvc + 1) % NVC;
         end
      end

      // VC allocation: first unbound non-empty VC, heads only
      for (p = 0; p < NPORT; p++) begin
         req_v[p] = -1;
         req_o[p] = -1;
         for (i = 0; i < NVC; i++) begin
            v = (va_ptr[p] + i) % NVC;
            if (vc_bound[p][v] || buf_cnt[p][v] == 0) continue;
            if (buf_type[p][v][buf_head[p][v]] == vcra_pkg::TYPE_HEAD) begin
               req_v[p] = v;
               req_o[p] = buf_route[p][v][buf_head[p][v]];
            end
            break;
         end
      end
      for (o = 0; o < NPORT; o++) begin
         for (p = 0; p < NPORT; p++) begin
            if (req_o[p] != o) continue;
            for (v = 0; v < NVC; v++) used[v] = 0;
            for (q = 0; q < NPORT; q++)
               for (v = 0; v < NVC; v++)
                  if (vc_bound[q][v] && bound_port[q][v] == o) used[bound_vc[q][v]] = 1;
            for (v = 0; v < NVC; v++) begin
               if (!used[v]) begin
                  vc_bound[p][req_v[p]]   = 1;
                  bound_port[p][req_v[p]] = o;
                  bound_vc[p][req_v[p]]   = v;
                  va_ptr[p] = (va_ptr[p] + 1) % NVC;
                  break;
               end
            end
         end
      end
   endfunction

   function automatic void predict_event(logic [1:0] kind, logic [2:0] port,
                                         logic [1:0] vc, logic [1:0] ftype,
                                         logic [15:0] tag, logic [2:0] route);
      int slot;
      if (kind == vcra_pkg::KIND_TICK) begin
         predict_tick();
         return;
      end
      if (port >= NPORT || vc >= NVC) return;
      if (kind == vcra_pkg::KIND_FLIT) begin
         if (buf_cnt[port][vc] < BDEPTH) begin
            slot = (buf_head[port][vc] + buf_cnt[port][vc]) % BDEPTH;
            buf_tag[port][vc][slot]   = tag;
            buf_type[port][vc][slot]  = ftype;
            buf_route[port][vc][slot] = (route >= NPORT) ? NPORT - 1 : int'(route);
            buf_cnt[port][vc]++;
         end
      end else if (kind == vcra_pkg::KIND_CREDIT) begin
         if (credits[port][vc] < depth_reg) credits[port][vc]++;
      end
   endfunction

   // one event transfer; the sender sometimes idles between bursts
   task automatic send_event(logic [1:0] kind, logic [2:0] port, logic [1:0] vc,
                             logic [1:0] ftype, logic [15:0] tag, logic [2:0] route);
      int gap;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_port       <= port;
      req_vchan      <= vc;
      req_flit_type  <= ftype;
      req_flit_tag   <= tag;
      req_route_port <= route;
      do @(posedge clock); while (req_stall);
      predict_event(kind, port, vc, ftype, tag, route);
      events_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic tick();
      send_event(vcra_pkg::KIND_TICK, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                 2'($urandom_range(0, 3)), 16'($urandom), 3'($urandom_range(0, 7)));
   endtask

   // wait until every predicted flit arrived and any tick has finished
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sent_q.size() != 0) @(negedge clock);
      repeat (IDLE_GAP) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [4:0] data);
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == vcra_pkg::CSR_DEPTH) depth_reg = data;
      else local_reg = data & 5'd7;
   endtask

   // directed: field extremes, odd inputs, full FIFO, headless body
   task automatic test_directed();
      int i;
      send_event(vcra_pkg::KIND_FLIT, 3'd0, 2'd0, vcra_pkg::TYPE_HEAD, 16'h0000, 3'd4);
      send_event(vcra_pkg::KIND_FLIT, 3'd0, 2'd0, TYPE_BODY, 16'hFFFF, 3'd0);
      send_event(vcra_pkg::KIND_FLIT, 3'd0, 2'd0, TYPE_ODD,  16'hA5A5, 3'd0);
      send_event(vcra_pkg::KIND_FLIT, 3'd0, 2'd0, vcra_pkg::TYPE_TAIL, 16'h5A5A, 3'd0);
      send_event(vcra_pkg::KIND_FLIT, 3'd3, 2'd3, vcra_pkg::TYPE_HEAD, 16'h1234, 3'd7);
      send_event(vcra_pkg::KIND_FLIT, 3'd3, 2'd3, vcra_pkg::TYPE_TAIL, 16'h4321, 3'd6);
      send_event(vcra_pkg::KIND_FLIT, 3'd7, 2'd3, vcra_pkg::TYPE_HEAD, 16'hFFFF, 3'd1);
      send_event(KIND_BAD,  3'd1, 2'd1, vcra_pkg::TYPE_HEAD, 16'hFFFF, 3'd1);
      send_event(vcra_pkg::KIND_CREDIT, 3'd4, 2'd0, vcra_pkg::TYPE_HEAD, 16'h0, 3'd0);
      send_event(vcra_pkg::KIND_CREDIT, 3'd5, 2'd2, vcra_pkg::TYPE_HEAD, 16'h0, 3'd0);
      // five heads into one four-deep FIFO: the last is dropped
      for (i = 0; i < 5; i++)
         send_event(vcra_pkg::KIND_FLIT, 3'd2, 2'd1, vcra_pkg::TYPE_HEAD,
                    16'(16'hC000 + i), 3'(i));
      // body with no head in front: this VC never gets a route
      send_event(vcra_pkg::KIND_FLIT, 3'd4, 2'd3, TYPE_BODY, 16'hBEEF, 3'd2);
      for (i = 0; i < 12; i++) tick();
   endtask

   // random packets with credits and ticks mixed in, plus some noise
   task automatic test_traffic(int n_events);
      int stop, len, k, p, v, r;
      stop = events_sent + n_events;
      while (events_sent < stop) begin
         if ($urandom_range(0, 9) == 0) begin
            send_event(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                       2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       16'($urandom), 3'($urandom_range(0, 7)));
            continue;
         end
         p = $urandom_range(0, NPORT - 1);
         v = $urandom_range(0, NVC - 1);
         r = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
         len = $urandom_range(1, 4);
         for (k = 0; k < len; k++) begin
            send_event(vcra_pkg::KIND_FLIT, 3'(p), 2'(v),
                       (k == 0) ? vcra_pkg::TYPE_HEAD
                                : (k == len - 1) ? vcra_pkg::TYPE_TAIL : TYPE_BODY,
                       16'($urandom), (k == 0) ? 3'(r) : 3'($urandom_range(0, 7)));
            if ($urandom_range(0, 2) == 0) tick();
            if ($urandom_range(0, 2) == 0)
               send_event(vcra_pkg::KIND_CREDIT, 3'($urandom_range(0, 4)),
                          2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          16'($urandom), 3'($urandom_range(0, 7)));
         end
         if (len == 1)
            send_event(vcra_pkg::KIND_FLIT, 3'(p), 2'(v), vcra_pkg::TYPE_TAIL,
                       16'($urandom), 3'($urandom_range(0, 7)));
         repeat ($urandom_range(1, 4)) tick();
      end
   endtask

   // receiver stall pattern: switches between free, light and heavy
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_run = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 75;
         endcase
      end
      stall_run--;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      sent_flit_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_port, rsp_out_vchan, rsp_sent_tag, rsp_sent_type,
                 rsp_credit_port, rsp_credit_vchan, rsp_last};
         if (sent_q.size() == 0) begin
            $display("%0t: unexpected flit transfer %h", $time, got);
            errors++;
         end else begin
            want = sent_q.pop_front();
            flits_checked++;
            if (got !== want) begin
               $display("%0t: flit mismatch expected port %0d vc %0d tag %h type %0d cport %0d cvc %0d last %0d",
                        $time, want.out_port, want.out_vchan, want.tag, want.ftype,
                        want.credit_port, want.credit_vchan, want.last);
               $display("%0t:                actual port %0d vc %0d tag %h type %0d cport %0d cvc %0d last %0d",
                        $time, got.out_port, got.out_vchan, got.tag, got.ftype,
                        got.credit_port, got.credit_vchan, got.last);
               errors++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      for (int p = 0; p < NPORT; p++) begin
         gnt_v[p] = 0; va_ptr[p] = 0; sin_ptr[p] = 0; sout_ptr[p] = 0;
         for (int v = 0; v < NVC; v++) begin
            buf_cnt[p][v] = 0; buf_head[p][v] = 0; vc_bound[p][v] = 0;
            credits[p][v] = 4;
         end
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_traffic(70);
      write_csr(vcra_pkg::CSR_DEPTH, 5'd1);
      write_csr(vcra_pkg::CSR_LOCAL, 5'd4);
      test_traffic(70);
      write_csr(vcra_pkg::CSR_DEPTH, 5'd16);
      write_csr(vcra_pkg::CSR_LOCAL, 5'd7);
      test_traffic(70);
      write_csr(vcra_pkg::CSR_DEPTH, 5'd3);
      write_csr(vcra_pkg::CSR_LOCAL, 5'd2);
      test_traffic(70);
      settle();

      $display("Ran %0d events over four register settings; %0d sent flits checked.",
               events_sent, flits_checked);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
src/vcra_pkg.sv
src/vcra_ram.sv
src/vc_router_allocator_core.sv
src/vcra_checker.sv
test/vc_router_allocator_core_tb.sv
